@@ rtl/packet_sequence_reorder_buffer_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the packet sequence reorder buffer
// Shared property templates; each module using them provides clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_REORDER_BUFFER_TOP_DEFINES_SVH
`define PACKET_SEQUENCE_REORDER_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSRB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/psrb_pkg.sv @@
// ---------------------------------------------------------------------------
// psrb_pkg
// Types shared by the reorder buffer top level and its flag store, and codes of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package psrb_pkg;

	// Result codes carried on the output tuser.
	localparam logic [2:0] V_SEARCH  = 3'd0;
	localparam logic [2:0] V_LOCKED  = 3'd1;
	localparam logic [2:0] V_STORED  = 3'd2;
	localparam logic [2:0] V_DUP     = 3'd3;
	localparam logic [2:0] V_OUTWIN  = 3'd4;
	localparam logic [2:0] V_RESYNC  = 3'd5;
	localparam logic [2:0] V_SYNCERR = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] R_SWITCH_FILL = 2'd0;
	localparam logic [1:0] R_BAD_LIMIT   = 2'd1;
	localparam logic [1:0] R_SYNC_RUN    = 2'd2;
	localparam logic [1:0] R_TRY_LIMIT   = 2'd3;

	localparam int BUF_W  = 4;
	localparam int SLOT_W = 16;
	localparam int MAX_BUFS = 16;

	// Request from the sequencer to the slot flag store.
	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic                clr_en;
		logic [BUF_W-1:0]    buf_idx;
		logic [SLOT_W-1:0]   slot;
		logic [MAX_BUFS-1:0] clr_mask;
	} flag_req_t;

	// Response from the slot flag store.
	typedef struct packed {
		logic present;
		logic busy;
	} flag_rsp_t;

endpackage

`default_nettype wire

@@ rtl/packet_sequence_reorder_buffer_top.sv @@
// ---------------------------------------------------------------------------
// packet_sequence_reorder_buffer_top
// Sequence-number reorder buffer: locks onto a packet stream, places each
// packet in a ring of slot buffers and hands buffers off with missing counts.
// ---------------------------------------------------------------------------
// Each accepted sequence number produces exactly one result beat. A packet that
// goes through the window test (compute, flag read, update, finish) has its
// result registered in the finish step, after the registered read of the slot
// flag memory and the read-modify-write on it; a search, resync or sync-error
// step skips the flag access and goes from compute straight to finish. The
// input is taken again only after the result is registered, so a new item is
// not accepted before the last one is through; one item is in flight at a time,
// and a held result stalls the input. After reset, and after a buffer has been
// cleared 255 times since the last sweep, the flag memory is swept over all
// BUFFER_COUNT * 2^ceil(log2(SLOTS_PER_BUFFER)) entries with s_tready low;
// configuration writes are taken.
`default_nettype none

`include "packet_sequence_reorder_buffer_top_defines.svh"

module packet_sequence_reorder_buffer_top #(
	parameter int SLOTS_PER_BUFFER = 1024,
	parameter int BUFFER_COUNT     = 3
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [63:0]  s_tdata,   // [63:0] sequence_number
	output logic         m_tvalid,
	input  wire          m_tready,
	// [3:0] buffer_index, [19:4] slot_index, [20] handoff, [24:21] handoff_buffer,
	// [41:25] handoff_missing, [73:42] got_count, [105:74] lost_count,
	// [137:106] bad_count, [143:138] zero
	output logic [143:0] m_tdata,
	output logic [2:0]   m_tuser,   // [2:0] verdict
	input  wire          cfg_we,
	input  wire  [1:0]   cfg_index,
	input  wire  [16:0]  cfg_data
);

	localparam logic [63:0] S64    = 64'(SLOTS_PER_BUFFER);
	localparam logic [63:0] S64X2  = 64'(2 * SLOTS_PER_BUFFER);
	localparam logic [16:0] S17    = 17'(SLOTS_PER_BUFFER);
	localparam logic [3:0]  LAST_B = 4'(BUFFER_COUNT - 1);
	localparam logic [15:0] ALL_MASK = 16'((32'd1 << BUFFER_COUNT) - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_RD,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t state_q;

	psrb_pkg::flag_req_t req;
	psrb_pkg::flag_rsp_t rsp;

	// configuration
	logic [16:0] switch_fill_q;
	logic [16:0] bad_limit_q;
	logic [3:0]  sync_run_q;
	logic [15:0] try_limit_q;

	// block state
	logic        locked_q;
	logic        have_prev_q;
	logic [3:0]  run_q;
	logic [15:0] tries_q;
	logic [63:0] prev_q;
	logic [63:0] wbase_q;
	logic [3:0]  cur_buf_q;
	logic [3:0]  fol_buf_q;
	logic [16:0] cur_fill_q;
	logic [16:0] fol_fill_q;
	logic [31:0] got_q;
	logic [31:0] lost_q;
	logic [31:0] bad_q;

	// item in flight
	logic [63:0] seq_q;
	logic        work_q;
	logic        lock_now_q;
	logic        inwin_q;
	logic        infol_q;
	logic [3:0]  buf_q;
	logic [15:0] slot_q;
	logic [2:0]  verdict_q;
	logic [3:0]  bidx_q;
	logic [15:0] sidx_q;

	// result register
	logic        m_tvalid_q;
	logic [2:0]  o_verdict_q;
	logic [3:0]  o_bidx_q;
	logic [15:0] o_slot_q;
	logic        o_ho_q;
	logic [3:0]  o_hob_q;
	logic [16:0] o_hom_q;
	logic [31:0] o_got_q;
	logic [31:0] o_lost_q;
	logic [31:0] o_bad_q;

	logic [63:0] diff_prev;
	logic [63:0] off_full;
	logic [63:0] off_fol;
	logic [3:0]  run_next;
	logic        lock_go;
	logic        calc_work;
	logic [2:0]  calc_verdict;
	logic        out_free;
	logic        handoff;
	logic        resync;
	logic [16:0] miss;
	logic [3:0]  new_fol;
	logic [31:0] lost_next;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [16:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign diff_prev = seq_q - prev_q;
	assign off_full  = seq_q - wbase_q;
	assign off_fol   = off_full - S64;
	assign run_next  = (diff_prev == 64'd1) ? ((run_q == 4'hF) ? run_q : run_q + 4'd1) : 4'd0;
	assign lock_go   = !locked_q && have_prev_q && (tries_q < try_limit_q)
		&& (run_next >= sync_run_q);
	assign calc_work = lock_go || (locked_q && have_prev_q);
	assign calc_verdict = (!locked_q && have_prev_q && (tries_q >= try_limit_q))
		? psrb_pkg::V_SYNCERR
		: ((locked_q && !have_prev_q) ? psrb_pkg::V_RESYNC : psrb_pkg::V_SEARCH);
	assign out_free  = !m_tvalid_q || m_tready;

	assign handoff   = (cur_fill_q == S17) || (fol_fill_q > switch_fill_q);
	assign miss      = S17 - cur_fill_q;
	assign lost_next = handoff ? sat_add32(lost_q, miss) : lost_q;
	assign new_fol   = (fol_buf_q == LAST_B) ? 4'd0 : fol_buf_q + 4'd1;
	assign resync    = bad_q > 32'(bad_limit_q);

	always_comb begin
		req          = '0;
		req.buf_idx  = buf_q;
		req.slot     = slot_q;
		if (state_q == ST_CALC && lock_go) begin
			req.clr_en   = 1'b1;
			req.clr_mask = ALL_MASK;
		end
		if (state_q == ST_RD && !rsp.busy) begin
			req.rd_en = 1'b1;
		end
		if (state_q == ST_UPD && inwin_q && !rsp.present) begin
			req.wr_en = 1'b1;
		end
		if (state_q == ST_FIN && out_free && work_q && (handoff || resync)) begin
			req.clr_en   = 1'b1;
			req.clr_mask = resync ? ALL_MASK : (16'd1 << new_fol);
		end
	end

	psrb_flag_mem #(
		.SLOTS_PER_BUFFER(SLOTS_PER_BUFFER),
		.BUFFER_COUNT    (BUFFER_COUNT)
	) u_flag_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	assign s_tready = (state_q == ST_IDLE) && !rsp.busy;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_verdict_q;
	assign m_tdata  = {6'd0, o_bad_q, o_lost_q, o_got_q, o_hom_q, o_hob_q, o_ho_q,
		o_slot_q, o_bidx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			switch_fill_q <= 17'd716;
			bad_limit_q   <= 17'd768;
			sync_run_q    <= 4'd3;
			try_limit_q   <= 16'd1024;
			locked_q      <= 1'b0;
			have_prev_q   <= 1'b0;
			run_q         <= '0;
			tries_q       <= '0;
			prev_q        <= '0;
			wbase_q       <= '0;
			cur_buf_q     <= 4'd0;
			fol_buf_q     <= 4'd1;
			cur_fill_q    <= '0;
			fol_fill_q    <= '0;
			got_q         <= '0;
			lost_q        <= '0;
			bad_q         <= '0;
			seq_q         <= '0;
			work_q        <= 1'b0;
			lock_now_q    <= 1'b0;
			inwin_q       <= 1'b0;
			infol_q       <= 1'b0;
			buf_q         <= '0;
			slot_q        <= '0;
			verdict_q     <= psrb_pkg::V_SEARCH;
			bidx_q        <= '0;
			sidx_q        <= '0;
			m_tvalid_q    <= 1'b0;
			o_verdict_q   <= psrb_pkg::V_SEARCH;
			o_bidx_q      <= '0;
			o_slot_q      <= '0;
			o_ho_q        <= 1'b0;
			o_hob_q       <= '0;
			o_hom_q       <= '0;
			o_got_q       <= '0;
			o_lost_q      <= '0;
			o_bad_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psrb_pkg::R_SWITCH_FILL: switch_fill_q <= cfg_data;
					psrb_pkg::R_BAD_LIMIT:   bad_limit_q   <= cfg_data;
					psrb_pkg::R_SYNC_RUN:    sync_run_q    <= cfg_data[3:0];
					psrb_pkg::R_TRY_LIMIT:   try_limit_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			// The finish step raises a new beat in the same cycle the old one leaves.
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && !rsp.busy) begin
						seq_q   <= s_tdata;
						state_q <= ST_CALC;
					end
				end

				ST_CALC: begin
					work_q     <= calc_work;
					lock_now_q <= lock_go;
					verdict_q  <= calc_verdict;
					bidx_q     <= '0;
					sidx_q     <= '0;
					state_q    <= calc_work ? ST_RD : ST_FIN;
					if (!locked_q) begin
						prev_q <= seq_q;
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							run_q       <= '0;
							tries_q     <= '0;
						end else if (tries_q >= try_limit_q) begin
							have_prev_q <= 1'b0;
							run_q       <= '0;
							tries_q     <= '0;
						end else begin
							tries_q <= tries_q + 16'd1;
							run_q   <= run_next;
							if (lock_go) begin
								// Lock: this packet opens the current window at slot 0.
								locked_q   <= 1'b1;
								cur_fill_q <= '0;
								fol_fill_q <= '0;
								wbase_q    <= seq_q;
								inwin_q    <= 1'b1;
								infol_q    <= 1'b0;
								buf_q      <= cur_buf_q;
								slot_q     <= '0;
							end
						end
					end else if (!have_prev_q) begin
						wbase_q     <= seq_q;
						have_prev_q <= 1'b1;
					end else begin
						if (off_full < S64) begin
							inwin_q <= 1'b1;
							infol_q <= 1'b0;
							buf_q   <= cur_buf_q;
							slot_q  <= off_full[15:0];
						end else if (off_full < S64X2) begin
							inwin_q <= 1'b1;
							infol_q <= 1'b1;
							buf_q   <= fol_buf_q;
							slot_q  <= off_fol[15:0];
						end else begin
							inwin_q <= 1'b0;
							infol_q <= 1'b0;
							buf_q   <= cur_buf_q;
							slot_q  <= '0;
						end
					end
				end

				ST_RD: begin
					if (!rsp.busy) begin
						state_q <= ST_UPD;
					end
				end

				ST_UPD: begin
					state_q <= ST_FIN;
					if (!inwin_q) begin
						verdict_q <= psrb_pkg::V_OUTWIN;
						bad_q     <= sat_add32(bad_q, 17'd1);
					end else if (rsp.present) begin
						verdict_q <= psrb_pkg::V_DUP;
						bad_q     <= sat_add32(bad_q, 17'd1);
					end else begin
						if (infol_q) begin
							fol_fill_q <= fol_fill_q + 17'd1;
						end else begin
							cur_fill_q <= cur_fill_q + 17'd1;
						end
						got_q     <= sat_add32(got_q, 17'd1);
						verdict_q <= lock_now_q ? psrb_pkg::V_LOCKED : psrb_pkg::V_STORED;
						bidx_q    <= buf_q;
						sidx_q    <= slot_q;
					end
				end

				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						o_verdict_q <= verdict_q;
						o_bidx_q    <= bidx_q;
						o_slot_q    <= sidx_q;
						o_ho_q      <= work_q && handoff;
						o_hob_q     <= (work_q && handoff) ? cur_buf_q : 4'd0;
						o_hom_q     <= (work_q && handoff) ? miss : 17'd0;
						o_got_q     <= (work_q && resync) ? 32'd0 : got_q;
						o_lost_q    <= work_q ? lost_next : lost_q;
						o_bad_q     <= (work_q && resync) ? 32'd0 : bad_q;
						state_q     <= ST_IDLE;
						if (work_q) begin
							if (handoff) begin
								lost_q    <= lost_next;
								cur_buf_q <= fol_buf_q;
								fol_buf_q <= new_fol;
								wbase_q   <= wbase_q + S64;
							end
							// A resync empties both windows after any handoff.
							if (handoff || resync) begin
								cur_fill_q <= resync ? 17'd0 : fol_fill_q;
								fol_fill_q <= '0;
							end
							if (resync) begin
								got_q       <= '0;
								bad_q       <= '0;
								have_prev_q <= 1'b0;
							end
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PSRB_ASSERT_SAME(a_fill_bound, 1'b1, cur_fill_q <= S17 && fol_fill_q <= S17,
		"buffer fill beyond slot count")
	`PSRB_ASSERT_SAME(a_lock_slot0, state_q == ST_UPD && lock_now_q,
		inwin_q && !infol_q && slot_q == 16'd0, "lock packet not at slot zero")
	`PSRB_ASSERT_NEXT(a_result_from_fin, !m_tvalid_q && state_q != ST_FIN, !m_tvalid_q,
		"result raised outside finish step")

endmodule

`default_nettype wire

@@ rtl/psrb_flag_mem.sv @@
// ---------------------------------------------------------------------------
// psrb_flag_mem
// Slot occupancy store: one epoch tag per slot in a synchronous memory.
// A slot is filled when its tag equals its buffer's epoch; clearing a buffer
// bumps that epoch. After reset and when an epoch would wrap, a sweep renormalizes all tags.
// ---------------------------------------------------------------------------
`default_nettype none

`include "packet_sequence_reorder_buffer_top_defines.svh"

module psrb_flag_mem #(
	parameter int SLOTS_PER_BUFFER = 1024,
	parameter int BUFFER_COUNT     = 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  psrb_pkg::flag_req_t   req,
	output psrb_pkg::flag_rsp_t   rsp
);

	localparam int SW    = $clog2(SLOTS_PER_BUFFER);
	localparam int BW    = $clog2(BUFFER_COUNT);
	localparam int AW    = BW + SW;
	localparam int DEPTH = BUFFER_COUNT * (1 << SW);
	localparam int EW    = 8;
	localparam logic [EW-1:0] EPOCH_MAX = '1;
	localparam logic [EW-1:0] EPOCH_ONE = EW'(1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [EW-1:0] tag_mem [DEPTH];

	logic [EW-1:0]           epoch_q [BUFFER_COUNT];
	logic                    busy_q;
	logic                    scan_go_q;
	logic                    scan_rd_q;
	logic [AW-1:0]           scan_addr_q;
	logic [AW-1:0]           wr_addr_s1;
	logic [AW-1:0]           lk_addr_s1;
	logic [BW-1:0]           lk_buf_s1;
	logic [BUFFER_COUNT-1:0] clr_mask_q;
	logic [EW-1:0]           rdata_q;

	logic [AW-1:0] lk_addr;
	logic [AW-1:0] rd_addr;
	logic [BW-1:0] sel_buf;
	logic [EW-1:0] sel_epoch;
	logic          keep;
	logic          wrap_need;

	assign lk_addr   = {req.buf_idx[BW-1:0], req.slot[SW-1:0]};
	assign rd_addr   = busy_q ? scan_addr_q : lk_addr;
	assign sel_buf   = busy_q ? wr_addr_s1[AW-1 -: BW] : lk_buf_s1;
	assign sel_epoch = epoch_q[sel_buf];
	assign keep      = (rdata_q == sel_epoch) && !clr_mask_q[sel_buf];

	assign rsp.present = (rdata_q == sel_epoch);
	assign rsp.busy    = busy_q;

	always_comb begin
		wrap_need = 1'b0;
		for (int b = 0; b < BUFFER_COUNT; b++) begin
			if (req.clr_mask[b] && epoch_q[b] == EPOCH_MAX) begin
				wrap_need = 1'b1;
			end
		end
	end

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (scan_rd_q) begin
			tag_mem[wr_addr_s1] <= keep ? EPOCH_ONE : '0;
		end else if (req.wr_en) begin
			tag_mem[lk_addr_s1] <= sel_epoch;
		end
		rdata_q <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			scan_go_q   <= 1'b1;
			scan_rd_q   <= 1'b0;
			scan_addr_q <= '0;
			wr_addr_s1  <= '0;
			lk_addr_s1  <= '0;
			lk_buf_s1   <= '0;
			clr_mask_q  <= '1;
			for (int b = 0; b < BUFFER_COUNT; b++) begin
				epoch_q[b] <= EPOCH_ONE;
			end
		end else begin
			if (req.rd_en) begin
				lk_addr_s1 <= lk_addr;
				lk_buf_s1  <= req.buf_idx[BW-1:0];
			end
			scan_rd_q  <= busy_q && scan_go_q;
			wr_addr_s1 <= scan_addr_q;
			if (busy_q) begin
				if (scan_go_q) begin
					if (scan_addr_q == LAST_ADDR) begin
						scan_go_q <= 1'b0;
					end else begin
						scan_addr_q <= scan_addr_q + AW'(1);
					end
				end
				// The sweep finishes once the last entry has been rewritten.
				if (scan_rd_q && wr_addr_s1 == LAST_ADDR) begin
					busy_q <= 1'b0;
					for (int b = 0; b < BUFFER_COUNT; b++) begin
						epoch_q[b] <= EPOCH_ONE;
					end
				end
			end else if (req.clr_en) begin
				if (wrap_need) begin
					busy_q      <= 1'b1;
					scan_go_q   <= 1'b1;
					scan_addr_q <= '0;
					clr_mask_q  <= req.clr_mask[BUFFER_COUNT-1:0];
				end else begin
					for (int b = 0; b < BUFFER_COUNT; b++) begin
						if (req.clr_mask[b]) begin
							epoch_q[b] <= epoch_q[b] + EPOCH_ONE;
						end
					end
				end
			end
		end
	end

	`PSRB_ASSERT_SAME(a_no_wr_in_sweep, busy_q, !req.wr_en, "slot write during sweep")
	`PSRB_ASSERT_SAME(a_no_clr_in_sweep, busy_q, !req.clr_en, "clear request during sweep")
	`PSRB_ASSERT_NEXT(a_sweep_end_epoch, busy_q && scan_rd_q && wr_addr_s1 == LAST_ADDR,
		!busy_q && epoch_q[0] == EPOCH_ONE, "epochs not renormalized after sweep")

endmodule

`default_nettype wire
